/* hw/rtl/mrld_pkg.sv */
// Shared constants, types and the control program of the mask run-length span decoder.
package mrld_pkg;

  // Frame size limits.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 64;
  localparam int MIN_WIDTH  = 8;

  // Run code layout.
  localparam int SHORT_CODE_LEN  = 3;
  localparam int LONG_CODE_LEN   = 8;
  localparam int LONG_RUN_ESCAPE = (1 << SHORT_CODE_LEN) - 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MSB_FIRST    = 2'd2;

  // Frame encodings.
  localparam logic [2:0] ENC_BLACK     = 3'd0;
  localparam logic [2:0] ENC_WHITE     = 3'd1;
  localparam logic [2:0] ENC_RLE_BLACK = 3'd2;
  localparam logic [2:0] ENC_RLE_WHITE = 3'd3;
  localparam logic [2:0] ENC_BITMAP    = 3'd4;

  // Datapath operations selected by a control word.
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_LATCH     = 4'd1;
  localparam op_t OP_FS_INIT   = 4'd2;
  localparam op_t OP_EMIT_FULL = 4'd3;
  localparam op_t OP_NORM_SUB  = 4'd4;
  localparam op_t OP_SAT       = 4'd5;
  localparam op_t OP_ACCUM     = 4'd6;
  localparam op_t OP_EMIT_RUN  = 4'd7;
  localparam op_t OP_ADV_FIX   = 4'd8;
  localparam op_t OP_ADD_RUN   = 4'd9;
  localparam op_t OP_TOGGLE    = 4'd10;
  localparam op_t OP_FIN       = 4'd11;
  localparam op_t OP_EMIT_BIT  = 4'd12;

  // Jump conditions.
  typedef logic [3:0] cond_t;
  localparam cond_t C_NEVER     = 4'd0;
  localparam cond_t C_ALWAYS    = 4'd1;
  localparam cond_t C_NO_IN     = 4'd2;
  localparam cond_t C_KIND_BIT  = 4'd3;
  localparam cond_t C_NOT_WENC  = 4'd4;
  localparam cond_t C_ROW_GE_H  = 4'd5;
  localparam cond_t C_NOT_FLAST = 4'd6;
  localparam cond_t C_DONE      = 4'd7;
  localparam cond_t C_COL_GE_W  = 4'd8;
  localparam cond_t C_BITMAP    = 4'd9;
  localparam cond_t C_NO_RUN    = 4'd10;
  localparam cond_t C_BLACK     = 4'd11;
  localparam cond_t C_WDONE     = 4'd12;

  // Program addresses.
  typedef logic [4:0] pc_t;
  localparam pc_t PC_IDLE    = 5'd0;
  localparam pc_t PC_FS      = 5'd2;
  localparam pc_t PC_FS_EMIT = 5'd4;
  localparam pc_t PC_BITS    = 5'd6;
  localparam pc_t PC_NORM0   = 5'd7;
  localparam pc_t PC_WLOOP   = 5'd11;
  localparam pc_t PC_BLK     = 5'd14;
  localparam pc_t PC_NORM1   = 5'd15;
  localparam pc_t PC_TOG     = 5'd17;
  localparam pc_t PC_FIN     = 5'd18;
  localparam pc_t PC_BM      = 5'd19;

  // One control word: datapath operation, jump condition and jump target.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } ucode_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic kind_bit;
    logic wenc;
    logic row_ge_h;
    logic flast;
    logic done;
    logic col_ge_w;
    logic bitmap;
    logic no_run;
    logic black;
    logic wdone;
    logic hold;
  } stat_t;

  // Control program. A step jumps to its target when its condition holds,
  // otherwise it falls through to the next step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      5'd0:  w = '{OP_LATCH,     C_NO_IN,     PC_IDLE};
      5'd1:  w = '{OP_NOP,       C_KIND_BIT,  PC_BITS};
      5'd2:  w = '{OP_FS_INIT,   C_NOT_WENC,  PC_IDLE};
      5'd3:  w = '{OP_NOP,       C_ROW_GE_H,  PC_IDLE};
      5'd4:  w = '{OP_EMIT_FULL, C_NOT_FLAST, PC_FS_EMIT};
      5'd5:  w = '{OP_NOP,       C_ALWAYS,    PC_IDLE};
      5'd6:  w = '{OP_NOP,       C_DONE,      PC_IDLE};
      5'd7:  w = '{OP_NORM_SUB,  C_COL_GE_W,  PC_NORM0};
      5'd8:  w = '{OP_SAT,       C_BITMAP,    PC_BM};
      5'd9:  w = '{OP_ACCUM,     C_NO_RUN,    PC_FIN};
      5'd10: w = '{OP_NOP,       C_BLACK,     PC_BLK};
      5'd11: w = '{OP_NOP,       C_WDONE,     PC_TOG};
      5'd12: w = '{OP_EMIT_RUN,  C_NEVER,     PC_IDLE};
      5'd13: w = '{OP_ADV_FIX,   C_ALWAYS,    PC_WLOOP};
      5'd14: w = '{OP_ADD_RUN,   C_NEVER,     PC_IDLE};
      5'd15: w = '{OP_NORM_SUB,  C_COL_GE_W,  PC_NORM1};
      5'd16: w = '{OP_SAT,       C_NEVER,     PC_IDLE};
      5'd17: w = '{OP_TOGGLE,    C_NEVER,     PC_IDLE};
      5'd18: w = '{OP_FIN,       C_ALWAYS,    PC_IDLE};
      5'd19: w = '{OP_EMIT_BIT,  C_NEVER,     PC_IDLE};
      5'd20: w = '{OP_ADV_FIX,   C_ALWAYS,    PC_FIN};
      default: w = '{OP_NOP,     C_ALWAYS,    PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/mrld_seq.sv */
// Step counter and control store of the span decoder's sequencer.
module mrld_seq
  import mrld_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output op_t   op
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  ucode_t word;
  logic   jump;

  assign word = ucode_rom(pc_r);
  assign op   = word.op;

  // Condition select.
  always_comb begin
    case (word.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_IN:     jump = !stat.in_valid;
      C_KIND_BIT:  jump = stat.kind_bit;
      C_NOT_WENC:  jump = !stat.wenc;
      C_ROW_GE_H:  jump = stat.row_ge_h;
      C_NOT_FLAST: jump = !stat.flast;
      C_DONE:      jump = stat.done;
      C_COL_GE_W:  jump = stat.col_ge_w;
      C_BITMAP:    jump = stat.bitmap;
      C_NO_RUN:    jump = stat.no_run;
      C_BLACK:     jump = stat.black;
      C_WDONE:     jump = stat.wdone;
      default:     jump = 1'b1;
    endcase
  end

  // Next step: hold while a span meets a full output register that is not being drained, else jump or fall through.
  always_comb begin
    if (stat.hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = word.tgt;
    end else begin
      pc_nxt = pc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* hw/rtl/mrld_dp.sv */
// Datapath of the span decoder: decode state, position arithmetic and output register.
module mrld_dp
  import mrld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [8:0] w_eff,
  input  logic [6:0] h_eff,
  input  logic       msb_first,
  input  logic       in_valid,
  input  logic       in_kind,
  input  logic [2:0] in_encoding,
  input  logic       in_mask_bit,
  input  logic       in_final_bit,
  input  op_t        op,
  output stat_t      stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [5:0] out_row,
  output logic [7:0] out_span_start,
  output logic [8:0] out_span_end,
  output logic       out_last
);

  // Latched input transaction.
  logic       kind_r, bit_r, fin_r;
  logic [2:0] enc_r;

  // Decode state.
  logic [2:0] mode_r, mode_nxt;
  logic       phase_r, phase_nxt;
  logic [3:0] bits_r, bits_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       white_r, white_nxt;
  logic [8:0] col_r, col_nxt;
  logic [6:0] row_r, row_nxt;
  logic       done_r, done_nxt;
  logic [7:0] left_r, left_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [5:0] out_row_r, out_row_nxt;
  logic [7:0] out_start_r, out_start_nxt;
  logic [8:0] out_end_r, out_end_nxt;
  logic       out_last_r, out_last_nxt;

  // Shared arithmetic.
  logic       col_ge_w, row_ge_h, flast;
  logic [7:0] row_p1;
  logic [8:0] room, left9, take, col_fix;
  logic [6:0] row_fix;
  logic [3:0] bits_inc, need;
  logic [7:0] acc_new;
  logic       complete, escape;
  logic       emit_req, hold;

  assign col_ge_w = (col_r >= w_eff);
  assign row_ge_h = (row_r >= h_eff);
  assign row_p1   = {1'b0, row_r} + 8'd1;
  assign flast    = (row_p1 >= {1'b0, h_eff});

  assign room  = w_eff - col_r;
  assign left9 = {1'b0, left_r};
  assign take  = (left9 < room) ? left9 : room;

  // One row carry: the column never reaches twice the width here.
  assign col_fix = col_ge_w ? (col_r - w_eff) : col_r;
  assign row_fix = row_r + {6'd0, col_ge_w};

  // Code accumulation for one mask bit.
  assign bits_inc = bits_r + 4'd1;
  assign need     = phase_r ? 4'(LONG_CODE_LEN) : 4'(SHORT_CODE_LEN);
  assign acc_new  = msb_first ? {acc_r[6:0], bit_r}
                              : (acc_r | ({7'd0, bit_r} << bits_r[2:0]));
  assign complete = (bits_inc >= need);
  assign escape   = !phase_r && (acc_new == 8'(LONG_RUN_ESCAPE));

  // Emission request and stall against a full output register.
  assign emit_req = (op == OP_EMIT_FULL) || (op == OP_EMIT_RUN) ||
                    ((op == OP_EMIT_BIT) && bit_r && !row_ge_h);
  assign hold     = emit_req && out_valid_r && !out_ready;

  always_comb begin
    stat.in_valid = in_valid;
    stat.kind_bit = kind_r;
    stat.wenc     = (enc_r == ENC_WHITE);
    stat.row_ge_h = row_ge_h;
    stat.flast    = flast;
    stat.done     = done_r;
    stat.col_ge_w = col_ge_w;
    stat.bitmap   = (mode_r == ENC_BITMAP);
    stat.no_run   = !(complete && !escape);
    stat.black    = !white_r;
    stat.wdone    = (left_r == 8'd0) || row_ge_h;
    stat.hold     = hold;
  end

  // Operation decode.
  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    bits_nxt      = bits_r;
    acc_nxt       = acc_r;
    white_nxt     = white_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    done_nxt      = done_r;
    left_nxt      = left_r;
    out_row_nxt   = out_row_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (!hold) begin
      case (op)
        OP_FS_INIT: begin
          mode_nxt  = enc_r;
          phase_nxt = 1'b0;
          bits_nxt  = 4'd0;
          acc_nxt   = 8'd0;
          white_nxt = (enc_r == ENC_RLE_WHITE);
          col_nxt   = 9'd0;
          row_nxt   = 7'd0;
          done_nxt  = !(enc_r inside {[ENC_RLE_BLACK:ENC_BITMAP]});
        end
        OP_EMIT_FULL: begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r[5:0];
          out_start_nxt = 8'd0;
          out_end_nxt   = w_eff;
          out_last_nxt  = flast;
          row_nxt       = row_p1[6:0];
        end
        OP_NORM_SUB: begin
          if (col_ge_w) begin
            col_nxt = col_r - w_eff;
            row_nxt = row_r + 7'd1;
          end
        end
        OP_SAT: begin
          if (row_ge_h) begin
            row_nxt = h_eff;
            col_nxt = 9'd0;
          end
        end
        OP_ACCUM: begin
          if (complete) begin
            bits_nxt  = 4'd0;
            acc_nxt   = 8'd0;
            phase_nxt = escape;
            left_nxt  = acc_new;
          end else begin
            bits_nxt = bits_inc;
            acc_nxt  = acc_new;
          end
        end
        OP_EMIT_RUN: begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r[5:0];
          out_start_nxt = col_r[7:0];
          out_end_nxt   = col_r + take;
          out_last_nxt  = (left9 == take) || ((take == room) && flast);
          col_nxt       = col_r + take;
          left_nxt      = left_r - take[7:0];
        end
        OP_ADV_FIX: begin
          if (row_fix >= h_eff) begin
            row_nxt = h_eff;
            col_nxt = 9'd0;
          end else begin
            row_nxt = row_fix;
            col_nxt = col_fix;
          end
        end
        OP_ADD_RUN: begin
          col_nxt = col_r + left9;
        end
        OP_TOGGLE: begin
          white_nxt = !white_r;
        end
        OP_FIN: begin
          if (fin_r) begin
            done_nxt  = 1'b1;
            phase_nxt = 1'b0;
            bits_nxt  = 4'd0;
            acc_nxt   = 8'd0;
          end
        end
        OP_EMIT_BIT: begin
          if (emit_req) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = row_r[5:0];
            out_start_nxt = col_r[7:0];
            out_end_nxt   = col_r + 9'd1;
            out_last_nxt  = 1'b1;
          end
          col_nxt = col_r + 9'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and decode state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ENC_BLACK;
      phase_r     <= 1'b0;
      bits_r      <= 4'd0;
      acc_r       <= 8'd0;
      white_r     <= 1'b0;
      col_r       <= 9'd0;
      row_r       <= 7'd0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      bits_r      <= bits_nxt;
      acc_r       <= acc_nxt;
      white_r     <= white_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    out_row_r   <= out_row_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_last_r  <= out_last_nxt;
    if ((op == OP_LATCH) && in_valid) begin
      kind_r <= in_kind;
      enc_r  <= in_encoding;
      bit_r  <= in_mask_bit;
      fin_r  <= in_final_bit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_span_start = out_start_r;
  assign out_span_end   = out_end_r;
  assign out_last       = out_last_r;

endmodule

/* hw/rtl/mask_run_length_span_decoder_top.sv */
// Top level of the mask run-length span decoder: configuration registers and block wiring.
//
// Decodes a frame's pixel mask into white spans (row, span_start, span_end), one
// input transaction at a time, under a microcoded sequencer that steps a small
// datapath. An input is taken only when the sequencer is at its idle step; a
// finished span waits in the output register while the next input is taken.
// A frame start initialises the decode state and, for a fully white frame, emits one
// full-width span per row. A mask bit outside a frame is dropped. A mask bit in a
// frame first carries the column into rows one width at a time and saturates the row
// at the height; in bitmap mode it then emits a one-pixel span when set, and in the
// run-length modes it adds the bit to the run code. A bit that completes a white run
// emits spans until the run is used up; one that completes a black run advances the
// column past it. A span that meets a full output register that is not being drained
// stalls the sequencer.
module mask_run_length_span_decoder_top
  import mrld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [2:0] in_encoding,
  input  logic       in_mask_bit,
  input  logic       in_final_bit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_row,
  output logic [7:0] out_span_start,
  output logic [8:0] out_span_end,
  output logic       out_last
);

  logic [8:0] frame_width_r;
  logic [6:0] frame_height_r;
  logic       msb_first_r;
  logic [8:0] w_eff;
  logic [6:0] h_eff;
  op_t        op;
  stat_t      stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 9'd72;
      frame_height_r <= 7'd16;
      msb_first_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[6:0];
        CFG_MSB_FIRST:    msb_first_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Effective frame size: width clamped to its range, height capped.
  always_comb begin
    if (frame_width_r < 9'(MIN_WIDTH)) begin
      w_eff = 9'(MIN_WIDTH);
    end else if (frame_width_r > 9'(MAX_WIDTH)) begin
      w_eff = 9'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_r;
    end
    if (frame_height_r > 7'(MAX_HEIGHT)) begin
      h_eff = 7'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  // Inputs are taken at the idle step only.
  assign in_ready = (op == OP_LATCH);

  mrld_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  mrld_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .w_eff          (w_eff),
    .h_eff          (h_eff),
    .msb_first      (msb_first_r),
    .in_valid       (in_valid),
    .in_kind        (in_kind),
    .in_encoding    (in_encoding),
    .in_mask_bit    (in_mask_bit),
    .in_final_bit   (in_final_bit),
    .op             (op),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_last       (out_last)
  );

endmodule
